// ----- rtl/imurc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imurc_pkg
// Types and constants shared by the frame decoder and calibrator modules.
// ----------------------------------------------------------------------------
package imurc_pkg;

    // Frame layout.
    localparam int FRAME_BYTES = 14;
    localparam int STORE_DEPTH = FRAME_BYTES - 1;
    localparam logic [3:0] LAST_POS = 4'(FRAME_BYTES - 1);

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_RATE_RANGE  = 3'd0;
    localparam logic [2:0] REG_ACCEL_RANGE = 3'd1;
    localparam logic [2:0] REG_ROW0        = 3'd2;
    localparam logic [2:0] REG_ROW1        = 3'd3;
    localparam logic [2:0] REG_ROW2        = 3'd4;
    localparam logic [2:0] REG_OFFSET      = 3'd5;

    // Reset values of the calibration matrix rows (identity in Q2.14).
    localparam logic [47:0] ROW0_RESET = 48'h0000_0000_4000;
    localparam logic [47:0] ROW1_RESET = 48'h0000_4000_0000;
    localparam logic [47:0] ROW2_RESET = 48'h4000_0000_0000;

    // Scale constants.
    localparam longint DEG2RAD_Q40 = 64'd19190098069;
    localparam logic [31:0] RATE_K0 = 32'((DEG2RAD_Q40 * 10 + 655) / 1310);
    localparam logic [31:0] RATE_K1 = 32'((DEG2RAD_Q40 * 10 + 327) / 655);
    localparam logic [31:0] RATE_K2 = 32'((DEG2RAD_Q40 * 10 + 164) / 328);
    localparam logic [31:0] RATE_K3 = 32'((DEG2RAD_Q40 * 10 + 82) / 164);
    localparam logic [31:0] G_Q24   = 32'd164528285;

    // Temperature: floor((raw * 51200 + 33387) / 66774) + 5376.
    // The numerator is biased positive by TEMP_BIAS_Q * TEMP_DIV.
    localparam logic [31:0] TEMP_MUL    = 32'd51200;
    localparam logic [31:0] TEMP_ROUND  = 32'd33387;
    localparam logic [31:0] TEMP_DIV    = 32'd66774;
    localparam logic [31:0] TEMP_BIAS_Q = 32'd25200;
    localparam logic [31:0] TEMP_NUM_BIAS = 32'(64'd25200 * 64'd66774);
    localparam logic [31:0] TEMP_RECIP  = 32'((64'd1 << 48) / 64'd66774);
    localparam logic [31:0] TEMP_OFFSET = 32'd5376;

    // Sequencer steps.
    localparam logic [5:0] STEP_RATE_END  = 6'd24;
    localparam logic [5:0] STEP_ACCEL_END = 6'd30;
    localparam logic [5:0] STEP_T_MUL     = 6'd30;
    localparam logic [5:0] STEP_T_ADD     = 6'd31;
    localparam logic [5:0] STEP_T_RECIP   = 6'd32;
    localparam logic [5:0] STEP_T_QUOT    = 6'd33;
    localparam logic [5:0] STEP_T_BACK    = 6'd34;
    localparam logic [5:0] STEP_LAST      = 6'd35;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_CALC,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MULM,    // matrix coefficient times raw rate
        OP_ADD,     // accumulate product
        OP_MULK,    // row sum times rate gain
        OP_RATE,    // round, remove bias, saturate
        OP_MULG,    // raw accel times g
        OP_ACCEL,   // round and saturate accel
        OP_TMUL,    // raw temperature times scale
        OP_TADD,    // add rounding and positive bias
        OP_TRECIP,  // times reciprocal of divisor
        OP_TQUOT,   // keep quotient estimate
        OP_TBACK,   // estimate times divisor
        OP_TFIX     // correct estimate, offset, saturate
    } op_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [15:0] temperature;
    } out_word_t;

    typedef struct packed {
        logic [1:0]             rate_range;
        logic [1:0]             accel_range;
        logic [2:0][2:0][15:0]  rows;
        logic [2:0][15:0]       offset;
    } cfg_t;

    typedef struct packed {
        logic       wr_en;
        logic [3:0] wr_pos;
        op_t        op;
        logic [1:0] axis;
        logic [1:0] col;
        logic       load;
    } cmd_t;

endpackage

// ----- rtl/imurc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imurc_ctrl
// Byte position tracking, compute sequencer and output handshake control.
// ----------------------------------------------------------------------------
module imurc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                frame_start,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output imurc_pkg::cmd_t     cmd
);

    imurc_pkg::state_t state_reg, state_next;
    logic [3:0] pos_reg, pos_next;
    logic [5:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic [3:0] eff_pos;
    logic       accept;
    logic [5:0] acc_step;

    // State, position, step and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imurc_pkg::ST_COLLECT;
            pos_reg       <= 4'd0;
            step_reg      <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != imurc_pkg::ST_COLLECT);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign eff_pos   = frame_start ? 4'd0 : pos_reg;
    assign acc_step  = step_reg - imurc_pkg::STEP_RATE_END;

    // Next state, sequencer decode and commands.
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.op         = imurc_pkg::OP_NONE;
        cmd.wr_pos     = eff_pos;

        unique case (state_reg)
            imurc_pkg::ST_COLLECT:
            begin
                if (accept)
                begin
                    cmd.wr_en = 1'b1;
                    if (eff_pos == imurc_pkg::LAST_POS)
                    begin
                        pos_next   = 4'd0;
                        step_next  = 6'd0;
                        state_next = imurc_pkg::ST_CALC;
                    end
                    else
                    begin
                        pos_next = eff_pos + 4'd1;
                    end
                end
            end
            imurc_pkg::ST_CALC:
            begin
                if (step_reg < imurc_pkg::STEP_RATE_END)
                begin
                    cmd.axis = step_reg[4:3];
                    cmd.col  = step_reg[2:1];
                    if (step_reg[2:0] == 3'd6)
                        cmd.op = imurc_pkg::OP_MULK;
                    else if (step_reg[2:0] == 3'd7)
                        cmd.op = imurc_pkg::OP_RATE;
                    else if (step_reg[0])
                        cmd.op = imurc_pkg::OP_ADD;
                    else
                        cmd.op = imurc_pkg::OP_MULM;
                end
                else if (step_reg < imurc_pkg::STEP_ACCEL_END)
                begin
                    cmd.axis = acc_step[2:1];
                    cmd.op   = acc_step[0] ? imurc_pkg::OP_ACCEL : imurc_pkg::OP_MULG;
                end
                else
                begin
                    unique case (step_reg)
                        imurc_pkg::STEP_T_MUL:   cmd.op = imurc_pkg::OP_TMUL;
                        imurc_pkg::STEP_T_ADD:   cmd.op = imurc_pkg::OP_TADD;
                        imurc_pkg::STEP_T_RECIP: cmd.op = imurc_pkg::OP_TRECIP;
                        imurc_pkg::STEP_T_QUOT:  cmd.op = imurc_pkg::OP_TQUOT;
                        imurc_pkg::STEP_T_BACK:  cmd.op = imurc_pkg::OP_TBACK;
                        default:                 cmd.op = imurc_pkg::OP_TFIX;
                    endcase
                end
                step_next = step_reg + 6'd1;
                if (step_reg == imurc_pkg::STEP_LAST)
                    state_next = imurc_pkg::ST_DONE;
            end
            imurc_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = imurc_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = imurc_pkg::ST_COLLECT;
            end
        endcase
    end

endmodule

// ----- rtl/imurc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imurc_dp
// Frame byte store, shared multiplier, accumulator and result registers.
// ----------------------------------------------------------------------------
module imurc_dp
(
    input  logic                clk,
    input  logic [7:0]          rx_byte,
    input  imurc_pkg::cfg_t     cfg,
    input  imurc_pkg::cmd_t     cmd,
    output imurc_pkg::out_word_t out_word
);

    logic [7:0]          store_reg [imurc_pkg::STORE_DEPTH];
    logic [7:0]          last_reg;
    logic signed [34:0]  acc_reg, acc_next;
    logic signed [68:0]  prod_reg;
    logic [16:0]         q0_reg;
    logic signed [31:0]  rate_res_reg [3];
    logic signed [31:0]  accel_res_reg [3];
    logic signed [15:0]  temp_res_reg;
    imurc_pkg::out_word_t out_reg;

    logic signed [15:0]  raw_accel [3];
    logic signed [15:0]  raw_rate [3];
    logic signed [15:0]  raw_temp;
    logic signed [35:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [68:0]  mul_p;
    logic [31:0]         rate_k;
    logic signed [68:0]  rate_t;
    logic [4:0]          ash;
    logic signed [68:0]  accel_t;
    logic signed [68:0]  rem_t;
    logic signed [18:0]  temp_q;

    function automatic logic signed [31:0] sat32(input logic signed [68:0] v);
        if (v > 69'sd2147483647)
            return 32'sh7fff_ffff;
        else if (v < -69'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767)
            return 16'sh7fff;
        else if (v < -19'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    // Raw words of the frame, big-endian.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            raw_accel[i] = {store_reg[2 * i], store_reg[2 * i + 1]};
        end
        raw_temp    = {store_reg[6], store_reg[7]};
        raw_rate[0] = {store_reg[8], store_reg[9]};
        raw_rate[1] = {store_reg[10], store_reg[11]};
        raw_rate[2] = {store_reg[12], last_reg};
    end

    // Gain for the selected gyro range.
    always_comb
    begin
        case (cfg.rate_range)
            2'd0:    rate_k = imurc_pkg::RATE_K0;
            2'd1:    rate_k = imurc_pkg::RATE_K1;
            2'd2:    rate_k = imurc_pkg::RATE_K2;
            default: rate_k = imurc_pkg::RATE_K3;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            imurc_pkg::OP_MULM:
            begin
                mul_a = 36'(signed'(cfg.rows[cmd.axis][cmd.col]));
                mul_b = 33'(raw_rate[cmd.col]);
            end
            imurc_pkg::OP_MULK:
            begin
                mul_a = 36'(acc_reg);
                mul_b = signed'({1'b0, rate_k});
            end
            imurc_pkg::OP_MULG:
            begin
                mul_a = 36'(raw_accel[cmd.axis]);
                mul_b = signed'({1'b0, imurc_pkg::G_Q24});
            end
            imurc_pkg::OP_TMUL:
            begin
                mul_a = 36'(raw_temp);
                mul_b = signed'({1'b0, imurc_pkg::TEMP_MUL});
            end
            imurc_pkg::OP_TRECIP:
            begin
                mul_a = 36'(acc_reg);
                mul_b = signed'({1'b0, imurc_pkg::TEMP_RECIP});
            end
            imurc_pkg::OP_TBACK:
            begin
                mul_a = signed'({19'd0, q0_reg});
                mul_b = signed'({1'b0, imurc_pkg::TEMP_DIV});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 69'(mul_a) * 69'(mul_b);

    // Rounding, bias, correction of the temperature quotient.
    assign rate_t  = ((prod_reg + (69'sd1 <<< 37)) >>> 38)
                     - 69'(signed'(cfg.offset[cmd.axis]));
    assign ash     = 5'd22 - {3'd0, cfg.accel_range};
    assign accel_t = (prod_reg + (69'sd1 <<< (ash - 5'd1))) >>> ash;
    assign rem_t   = 69'(acc_reg) - prod_reg;
    assign temp_q  = signed'({2'd0, q0_reg})
                     + ((rem_t >= signed'(69'(imurc_pkg::TEMP_DIV))) ? 19'sd1 : 19'sd0)
                     - 19'(imurc_pkg::TEMP_BIAS_Q) + 19'(imurc_pkg::TEMP_OFFSET);

    // Accumulator update.
    always_comb
    begin
        acc_next = acc_reg;
        case (cmd.op)
            imurc_pkg::OP_ADD:
            begin
                if (cmd.col == 2'd0)
                    acc_next = prod_reg[34:0];
                else
                    acc_next = acc_reg + prod_reg[34:0];
            end
            imurc_pkg::OP_TADD:
            begin
                acc_next = prod_reg[34:0] + 35'(imurc_pkg::TEMP_ROUND)
                           + 35'(imurc_pkg::TEMP_NUM_BIAS);
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            if (cmd.wr_pos == imurc_pkg::LAST_POS)
                last_reg <= rx_byte;
            else
                store_reg[cmd.wr_pos] <= rx_byte;
        end
        acc_reg  <= acc_next;
        prod_reg <= mul_p;
        if (cmd.op == imurc_pkg::OP_TQUOT)
            q0_reg <= prod_reg[64:48];
        if (cmd.op == imurc_pkg::OP_RATE)
            rate_res_reg[cmd.axis] <= sat32(rate_t);
        if (cmd.op == imurc_pkg::OP_ACCEL)
            accel_res_reg[cmd.axis] <= sat32(accel_t);
        if (cmd.op == imurc_pkg::OP_TFIX)
            temp_res_reg <= sat16(temp_q);
        if (cmd.load)
        begin
            out_reg.rate_x      <= rate_res_reg[0];
            out_reg.rate_y      <= rate_res_reg[1];
            out_reg.rate_z      <= rate_res_reg[2];
            out_reg.accel_x     <= accel_res_reg[0];
            out_reg.accel_y     <= accel_res_reg[1];
            out_reg.accel_z     <= accel_res_reg[2];
            out_reg.temperature <= temp_res_reg;
        end
    end

    assign out_word = out_reg;

endmodule

// ----- rtl/imu_rate_accel_frame_calibrate_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_rate_accel_frame_calibrate_core
// Sensor frame decoder with accel scaling, rate calibration and temperature.
// ----------------------------------------------------------------------------
// Bytes 0..12 of a frame are taken one per cycle. The last byte starts a
// 36-step sequence on the one shared multiplier; the word is then loaded into
// the output register once that register is free (not valid or not stalled).
// Input is stalled from the last byte until the word is loaded.
// Reset clears the byte position, sequencer and valid; the configuration
// registers take their reset values; datapath registers are not reset.
module imu_rate_accel_frame_calibrate_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  imurc_pkg::in_word_t   in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output imurc_pkg::out_word_t  out_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [5:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);

    imurc_pkg::cfg_t cfg_reg;
    imurc_pkg::cmd_t cmd;
    logic [2:0]      reg_idx;
    logic            wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_range  <= 2'd0;
            cfg_reg.accel_range <= 2'd0;
            cfg_reg.rows[0]     <= imurc_pkg::ROW0_RESET;
            cfg_reg.rows[1]     <= imurc_pkg::ROW1_RESET;
            cfg_reg.rows[2]     <= imurc_pkg::ROW2_RESET;
            cfg_reg.offset      <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                imurc_pkg::REG_RATE_RANGE:  cfg_reg.rate_range  <= pwdata[1:0];
                imurc_pkg::REG_ACCEL_RANGE: cfg_reg.accel_range <= pwdata[1:0];
                imurc_pkg::REG_ROW0:        cfg_reg.rows[0]     <= pwdata[47:0];
                imurc_pkg::REG_ROW1:        cfg_reg.rows[1]     <= pwdata[47:0];
                imurc_pkg::REG_ROW2:        cfg_reg.rows[2]     <= pwdata[47:0];
                imurc_pkg::REG_OFFSET:      cfg_reg.offset      <= pwdata[47:0];
                default:                    cfg_reg.offset      <= cfg_reg.offset;
            endcase
        end
    end

    // Register read decode.
    always_comb
    begin
        unique case (reg_idx)
            imurc_pkg::REG_RATE_RANGE:  prdata = {62'd0, cfg_reg.rate_range};
            imurc_pkg::REG_ACCEL_RANGE: prdata = {62'd0, cfg_reg.accel_range};
            imurc_pkg::REG_ROW0:        prdata = {16'd0, cfg_reg.rows[0]};
            imurc_pkg::REG_ROW1:        prdata = {16'd0, cfg_reg.rows[1]};
            imurc_pkg::REG_ROW2:        prdata = {16'd0, cfg_reg.rows[2]};
            imurc_pkg::REG_OFFSET:      prdata = {16'd0, cfg_reg.offset};
            default:                    prdata = 64'd0;
        endcase
    end

    imurc_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .frame_start (in_word.frame_start),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd)
    );

    imurc_dp u_dp
    (
        .clk      (clk),
        .rx_byte  (in_word.rx_byte),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .out_word (out_word)
    );

endmodule
